// File: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int PROD_W = 32;
    localparam int TERM_W = 35;
    localparam int QTR_W  = 31;
    localparam int SQ_W   = 60;
    localparam int SQ_STEPS = 30;
    localparam int CRD_W  = 40;
    localparam int ACC_W  = 32;
    localparam int PRE_STAGES = 5;

    typedef struct packed {
        logic signed [TERM_W-1:0] r21;
        logic signed [TERM_W-1:0] r22;
        logic signed [TERM_W-1:0] r10;
        logic signed [TERM_W-1:0] r00;
        logic signed [QTR_W-1:0]  c;
    } qte_terms_t;

    function automatic logic [ACC_W-1:0] atan_step(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/quaternion_to_euler_rpy_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_rpy_unit
// Unit quaternion (Q1.14) to roll, pitch and yaw binary angles (Z-Y-X order).
// ----------------------------------------------------------------------------
// Input channel s_*: one quaternion per item. Output channel m_*: one set of
// three angles per item, 32768 standing for pi; pitch is held to +-16384.
// The pipeline holds the product and matrix-term registers, 30 square-root
// digit cells for the pitch denominator, one quadrant fold and one cell per
// CORDIC stage, then the output register. One item is taken per cycle; the
// whole pipeline advances together, so throughput is one item per cycle while
// results are taken. When the receiver stalls with a result waiting, the
// pipeline and s_tready hold until it is taken. Reset clears all valid flags;
// no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_rpy_unit #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);
    localparam int DEPTH = qte_pkg::PRE_STAGES + qte_pkg::SQ_STEPS + 1 + CORDIC_STAGES + 1;
    localparam int PW = qte_pkg::PROD_W;
    localparam int TW = qte_pkg::TERM_W;
    localparam int QW = qte_pkg::QTR_W;
    localparam int SW = qte_pkg::SQ_W;
    localparam int CW = qte_pkg::CRD_W;
    localparam int AW = qte_pkg::ACC_W;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end

    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [PW-1:0] xz_reg, wy_reg, yz_reg, wx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
        end
    end

    localparam logic signed [TW-1:0] ONE = TW'(1) << 28;

    qte_pkg::qte_terms_t t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [TW-1:0] r20_reg;
    logic signed [QW-1:0] a3_reg, b3_reg;
    logic [SW-1:0] sqa_reg, sqb_reg, sum_reg;
    logic signed [TW-1:0] r20q, r21q, r22q;
    logic signed [2*QW-1:0] a_sq, b_sq;

    always_comb
    begin
        r20q = (r20_reg + (r20_reg[TW-1] ? TW'(15) : TW'(0))) >>> 4;
        r21q = (t2_reg.r21 + (t2_reg.r21[TW-1] ? TW'(15) : TW'(0))) >>> 4;
        r22q = (t2_reg.r22 + (t2_reg.r22[TW-1] ? TW'(15) : TW'(0))) >>> 4;
        a_sq = a3_reg * a3_reg;
        b_sq = b3_reg * b3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg.r00 <= ONE - 2 * (TW'(yy_reg) + TW'(zz_reg));
            t2_reg.r10 <= 2 * (TW'(xy_reg) + TW'(wz_reg));
            r20_reg    <= 2 * (TW'(xz_reg) - TW'(wy_reg));
            t2_reg.r21 <= 2 * (TW'(yz_reg) + TW'(wx_reg));
            t2_reg.r22 <= ONE - 2 * (TW'(xx_reg) + TW'(yy_reg));
            t2_reg.c   <= '0;

            t3_reg.r21 <= t2_reg.r21;
            t3_reg.r22 <= t2_reg.r22;
            t3_reg.r10 <= t2_reg.r10;
            t3_reg.r00 <= t2_reg.r00;
            t3_reg.c   <= QW'(-r20q);
            a3_reg     <= QW'(r21q);
            b3_reg     <= QW'(r22q);

            t4_reg  <= t3_reg;
            sqa_reg <= SW'(a_sq);
            sqb_reg <= SW'(b_sq);

            t5_reg  <= t4_reg;
            sum_reg <= sqa_reg + sqb_reg;
        end
    end

    logic [SW-1:0] ns [qte_pkg::SQ_STEPS+1];
    logic [SW-1:0] rs [qte_pkg::SQ_STEPS+1];
    qte_pkg::qte_terms_t td_reg [qte_pkg::SQ_STEPS];

    assign ns[0] = sum_reg;
    assign rs[0] = '0;

    for (genvar j = 0; j < qte_pkg::SQ_STEPS; j++)
    begin : g_sqrt
        qte_sqrt_cell #(.K(qte_pkg::SQ_STEPS - 1 - j)) u_sq (
            .clk     (clk),
            .en      (en),
            .n_in    (ns[j]),
            .root_in (rs[j]),
            .n_reg   (ns[j+1]),
            .root_reg(rs[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            td_reg[0] <= t5_reg;
            for (int k = 1; k < qte_pkg::SQ_STEPS; k++)
                td_reg[k] <= td_reg[k-1];
        end
    end

    qte_pkg::qte_terms_t tl;
    logic signed [CW-1:0] hx;
    assign tl = td_reg[qte_pkg::SQ_STEPS-1];
    assign hx = CW'(rs[qte_pkg::SQ_STEPS][29:0]);

    logic [AW-1:0] roll_acc, pitch_acc, yaw_acc;
    logic          roll_z, pitch_z, yaw_z;

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .en(en), .y_in(CW'(tl.r21)), .x_in(CW'(tl.r22)),
        .acc_out(roll_acc), .zero_out(roll_z)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .en(en), .y_in(CW'(tl.c)), .x_in(hx),
        .acc_out(pitch_acc), .zero_out(pitch_z)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .en(en), .y_in(CW'(tl.r10)), .x_in(CW'(tl.r00)),
        .acc_out(yaw_acc), .zero_out(yaw_z)
    );

    logic [AW-1:0] roll_rnd, pitch_rnd, yaw_rnd;
    logic signed [15:0] pitch_raw, pitch_sat;
    logic [47:0] out_next, out_reg;

    always_comb
    begin
        roll_rnd  = roll_acc + AW'(32'h8000);
        pitch_rnd = pitch_acc + AW'(32'h8000);
        yaw_rnd   = yaw_acc + AW'(32'h8000);
        pitch_raw = pitch_z ? 16'sd0 : pitch_rnd[31:16];
        if (pitch_raw > 16'sd16384)
            pitch_sat = 16'sd16384;
        else if (pitch_raw < -16'sd16384)
            pitch_sat = -16'sd16384;
        else
            pitch_sat = pitch_raw;
        out_next[15:0]  = roll_z ? 16'd0 : roll_rnd[31:16];
        out_next[31:16] = pitch_sat;
        out_next[47:32] = yaw_z ? 16'd0 : yaw_rnd[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_tdata = out_reg;

`ifndef SYNTH
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384 &&
                      $signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("pitch out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item lost at entry");
`endif
endmodule
`default_nettype wire

// File: rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit step of the pipelined integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [qte_pkg::SQ_W-1:0]     n_in,
    input  wire logic [qte_pkg::SQ_W-1:0]     root_in,
    output logic      [qte_pkg::SQ_W-1:0]     n_reg,
    output logic      [qte_pkg::SQ_W-1:0]     root_reg
);
    localparam logic [qte_pkg::SQ_W-1:0] BIT = qte_pkg::SQ_W'(1) << (2 * K);

    logic [qte_pkg::SQ_W-1:0] trial;
    logic [qte_pkg::SQ_W-1:0] n_next;
    logic [qte_pkg::SQ_W-1:0] root_next;

    always_comb
    begin
        trial = root_in + BIT;
        if (n_in >= trial)
        begin
            n_next    = n_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            n_next    = n_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            root_reg <= root_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qte_pkg::CRD_W-1:0]  x_in,
    input  wire logic signed [qte_pkg::CRD_W-1:0]  y_in,
    input  wire logic        [qte_pkg::ACC_W-1:0]  acc_in,
    input  wire logic                              zero_in,
    output logic signed      [qte_pkg::CRD_W-1:0]  x_reg,
    output logic signed      [qte_pkg::CRD_W-1:0]  y_reg,
    output logic             [qte_pkg::ACC_W-1:0]  acc_reg,
    output logic                                   zero_reg
);
    localparam logic [qte_pkg::ACC_W-1:0] STEP = qte_pkg::atan_step(STAGE);

    logic signed [qte_pkg::CRD_W-1:0] x_next;
    logic signed [qte_pkg::CRD_W-1:0] y_next;
    logic        [qte_pkg::ACC_W-1:0] acc_next;

    always_comb
    begin
        if (!y_in[qte_pkg::CRD_W-1])
        begin
            x_next   = x_in + (y_in >>> STAGE);
            y_next   = y_in - (x_in >>> STAGE);
            acc_next = acc_in + STEP;
        end
        else
        begin
            x_next   = x_in - (y_in >>> STAGE);
            y_next   = y_in + (x_in >>> STAGE);
            acc_next = acc_in - STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            zero_reg <= zero_in;
        end
    end
endmodule
`default_nettype wire

// File: rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2: quadrant fold followed by a row of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qte_pkg::CRD_W-1:0]  y_in,
    input  wire logic signed [qte_pkg::CRD_W-1:0]  x_in,
    output logic             [qte_pkg::ACC_W-1:0]  acc_out,
    output logic                                   zero_out
);
    logic signed [qte_pkg::CRD_W-1:0] xs [STAGES+1];
    logic signed [qte_pkg::CRD_W-1:0] ys [STAGES+1];
    logic        [qte_pkg::ACC_W-1:0] accs [STAGES+1];
    logic                             zs [STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zs[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[qte_pkg::CRD_W-1])
            begin
                xs[0]   <= -x_in;
                ys[0]   <= -y_in;
                accs[0] <= qte_pkg::ACC_W'(1) << (qte_pkg::ACC_W - 1);
            end
            else
            begin
                xs[0]   <= x_in;
                ys[0]   <= y_in;
                accs[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        qte_cordic_cell #(.STAGE(i)) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (xs[i]),
            .y_in    (ys[i]),
            .acc_in  (accs[i]),
            .zero_in (zs[i]),
            .x_reg   (xs[i+1]),
            .y_reg   (ys[i+1]),
            .acc_reg (accs[i+1]),
            .zero_reg(zs[i+1])
        );
    end

    assign acc_out  = accs[STAGES];
    assign zero_out = zs[STAGES];
endmodule
`default_nettype wire

// File: tb/quaternion_to_euler_rpy_unit_chk.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_rpy_unit_chk
// Watches both item channels, predicts roll, pitch and yaw for every accepted
// quaternion with an integer CORDIC model and compares against the results.
// ----------------------------------------------------------------------------
module quaternion_to_euler_rpy_unit_chk #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ANG_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

    logic [47:0] angles_due[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] vec_angle(longint y, longint x);
        logic [31:0] acc;
        longint dx;
        longint dy;
        acc = '0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                acc += ANG_TAB[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                acc -= ANG_TAB[i];
            end
        end
        acc = acc + 32'h8000;
        return acc[31:16];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic logic [47:0] euler_of(logic [63:0] q);
        longint w, x, y, z, r00, r10, r20, r21, r22, a, b, c, h;
        logic [15:0] roll, yaw, pr;
        int ps;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        r00 = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        r10 = 2 * (x * y + w * z);
        r20 = 2 * (x * z - w * y);
        r21 = 2 * (y * z + w * x);
        r22 = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        a = r21 / 16;
        b = r22 / 16;
        c = -(r20 / 16);
        h = int_sqrt(longint'(a * a + b * b));
        roll = vec_angle(r21, r22);
        yaw = vec_angle(r10, r00);
        pr = vec_angle(c, h);
        ps = int'($signed(pr));
        if (ps > 16384)
            ps = 16384;
        if (ps < -16384)
            ps = -16384;
        return {yaw, ps[15:0], roll};
    endfunction

    assign pending = angles_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [47:0] want;
        if (!rst_n)
        begin
            errors <= 0;
            angles_due.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                angles_due.push_back(euler_of(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (angles_due.size() == 0)
                begin
                    $display("%0t: unexpected item, actual %h", $realtime, m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = angles_due.pop_front();
                    if (want !== m_tdata)
                    begin
                        $display("%0t: roll/pitch/yaw expected %0d %0d %0d actual %0d %0d %0d",
                                 $realtime, $signed(want[15:0]), $signed(want[31:16]),
                                 $signed(want[47:32]), $signed(m_tdata[15:0]),
                                 $signed(m_tdata[31:16]), $signed(m_tdata[47:32]));
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/quaternion_to_euler_rpy_unit_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_rpy_unit_tb
// Drives directed and random quaternions with random gaps and output stalls,
// including one long stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module quaternion_to_euler_rpy_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1230;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // roll_angle, pitch_angle, yaw_angle
    int          errors;
    int          pending;
    int          sent;
    bit          tx_done;
    bit          rx_mode;

    quaternion_to_euler_rpy_unit DUT (.*);

    quaternion_to_euler_rpy_unit_chk CHK (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] rnd_comp(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 32768) - 16384);
            1: return 16'($urandom_range(0, 200) - 100);
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 1) ? 16384 : -16384);
        endcase
    endfunction

    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        int gap;
        gap = $urandom_range(0, 18);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // roughly unit quaternion with random axis
    task automatic send_unit();
        real a, b, c, d, n;
        a = $urandom_range(0, 20000) - 10000.0;
        b = $urandom_range(0, 20000) - 10000.0;
        c = $urandom_range(0, 20000) - 10000.0;
        d = $urandom_range(0, 20000) - 10000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial
    begin
        int r;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        sent = 0;
        tx_done = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
        send_quat(-16'sd16384, 16'd0, 16'd0, 16'd0);
        send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
        send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
        send_quat(16'd0, 16'd0, 16'd0, -16'sd16384);
        send_quat(16'd0, 16'd0, 16'd0, 16'd0);
        send_quat(16'd11585, 16'd0, 16'd11585, 16'd0);
        send_quat(16'd11585, 16'd0, -16'sd11585, 16'd0);
        send_quat(16'd11585, 16'd100, 16'd11585, 16'd0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_quat(16'd0, 16'd16384, 16'd0, 16'd1);
        send_quat(16'd0, 16'd16384, 16'd0, -16'sd1);
        send_quat(16'd1, 16'd0, 16'd0, 16'd16384);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                send_unit();
            else
                send_quat(rnd_comp(r - 7), rnd_comp($urandom_range(0, 3)),
                          rnd_comp($urandom_range(0, 3)), rnd_comp($urandom_range(0, 3)));
        end
        s_tvalid <= 1'b0;
        tx_done = 1'b1;
    end

    initial
    begin
        int hold;
        int gap;
        m_tready = 1'b0;
        rx_mode = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sent >= 300 && !rx_mode)
            begin
                rx_mode = 1'b1;
                m_tready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
            end
            if (sent < 600 || sent > 900)
            begin
                gap = $urandom_range(0, 18);
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
                while (!m_tvalid)
                    @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        wait (tx_done);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d quaternions: identity, axis half-turns, gimbal lock,", sent);
        $display("zero and out-of-range inputs, random poses, gaps and a long output stall.");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: quaternion_to_euler_rpy_unit.f
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_rpy_unit.sv
tb/quaternion_to_euler_rpy_unit_chk.sv
tb/quaternion_to_euler_rpy_unit_tb.sv
